// ===== src/kwsub_pkg.sv =====
// Shared types and constants for the keyword substitution cipher.
// Used by the controller, the datapath and the top level.
package kwsub_pkg;

  localparam int unsigned ALPHA_SIZE = 26;
  localparam int unsigned IDX_W      = 5;

  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ALPHA_SIZE - 1);
  localparam logic [IDX_W:0]   FULL_CNT = (IDX_W + 1)'(ALPHA_SIZE);

  localparam logic [7:0] CHAR_LOWER_A = 8'h61;
  localparam logic [7:0] CHAR_LOWER_Z = 8'h7a;
  localparam logic [7:0] CHAR_UPPER_A = 8'h41;
  localparam logic [7:0] CHAR_UPPER_Z = 8'h5a;

  typedef enum logic [1:0] {
    CMD_START  = 2'd0,
    CMD_LETTER = 2'd1,
    CMD_CLOSE  = 2'd2,
    CMD_TEXT   = 2'd3
  } cmd_t;

  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_WALK = 1'b1
  } state_t;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic clear;
    logic letter;
    logic walk_init;
    logic walk_step;
    logic walk_finish;
    logic text;
  } dp_cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic table_ready;
    logic walk_last;
  } dp_status_t;

endpackage

// ===== src/kwsub_ctrl.sv =====
// Controller state machine for the keyword substitution cipher.
// Depends on kwsub_pkg; drives the datapath through dp_cmd_t.
module kwsub_ctrl
  import kwsub_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  input  logic [1:0] cmd,
  input  dp_status_t status,
  output dp_cmd_t    dp_cmd,
  output logic       busy
);

  state_t state;
  state_t state_next;
  cmd_t   cmd_in;

  assign cmd_in = cmd_t'(cmd);

  // Advance state
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (start && cmd_in == CMD_CLOSE && !status.table_ready) begin
          state_next = ST_WALK;
        end
      end
      ST_WALK: begin
        if (status.walk_last) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Outputs: decode accepted beats, sequence the alphabet walk
  always_comb begin
    dp_cmd = '0;
    busy   = 1'b0;
    unique case (state)
      ST_IDLE: begin
        if (start) begin
          unique case (cmd_in)
            CMD_START:  dp_cmd.clear     = 1'b1;
            CMD_LETTER: dp_cmd.letter    = 1'b1;
            CMD_CLOSE:  dp_cmd.walk_init = !status.table_ready;
            CMD_TEXT:   dp_cmd.text      = 1'b1;
            default:    dp_cmd           = '0;
          endcase
        end
      end
      ST_WALK: begin
        busy               = 1'b1;
        dp_cmd.walk_step   = 1'b1;
        dp_cmd.walk_finish = status.walk_last;
      end
      default: busy = 1'b0;
    endcase
  end

endmodule

// ===== src/kwsub_dp.sv =====
// Datapath for the keyword substitution cipher: tables, build state, lookup.
// Depends on kwsub_pkg; commanded by kwsub_ctrl.
module kwsub_dp
  import kwsub_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  dp_cmd_t    dp_cmd,
  input  logic [7:0] symbol,
  input  logic       decrypt_mode_we,
  input  logic       decrypt_mode,
  output dp_status_t status,
  output logic       out_valid,
  output logic [7:0] out_char
);

  logic [IDX_W-1:0] forward_table [ALPHA_SIZE];
  logic [IDX_W-1:0] inverse_table [ALPHA_SIZE];
  logic [ALPHA_SIZE-1:0] letter_used;
  logic [IDX_W:0]   fill_count;
  logic [IDX_W-1:0] last_letter;
  logic             have_last;
  logic             table_ready;
  logic             mode_decrypt;
  logic [IDX_W-1:0] walk_pos;
  logic [IDX_W-1:0] walk_cnt;

  logic             is_lower;
  logic             is_upper;
  logic [7:0]       lower_off;
  logic [7:0]       upper_off;
  logic             letter_ok;
  logic [IDX_W-1:0] place_idx;
  logic             place_en;
  logic [IDX_W-1:0] look_idx;
  logic [IDX_W-1:0] look_val;
  logic [7:0]       char_base;
  logic [7:0]       text_res;

  // Classify the incoming byte
  assign is_lower  = (symbol >= CHAR_LOWER_A) && (symbol <= CHAR_LOWER_Z);
  assign is_upper  = (symbol >= CHAR_UPPER_A) && (symbol <= CHAR_UPPER_Z);
  assign lower_off = symbol - CHAR_LOWER_A;
  assign upper_off = symbol - CHAR_UPPER_A;
  assign letter_ok = dp_cmd.letter && !table_ready && is_lower;

  // Pick the letter to place and check it is new
  assign place_idx = dp_cmd.walk_step ? walk_pos : lower_off[IDX_W-1:0];
  assign place_en  = (letter_ok || dp_cmd.walk_step) && (fill_count < FULL_CNT)
                     && !letter_used[place_idx];

  // Table lookup for a text beat
  assign look_idx  = is_upper ? upper_off[IDX_W-1:0] : lower_off[IDX_W-1:0];
  assign look_val  = mode_decrypt ? inverse_table[look_idx] : forward_table[look_idx];
  assign char_base = is_upper ? CHAR_UPPER_A : CHAR_LOWER_A;
  assign text_res  = (table_ready && (is_upper || is_lower))
                     ? char_base + {{(8-IDX_W){1'b0}}, look_val} : symbol;

  assign status.table_ready = table_ready;
  assign status.walk_last   = (walk_cnt == LAST_IDX);

  // Hold the mode register
  always_ff @(posedge clk) begin
    if (rst) begin
      mode_decrypt <= 1'b0;
    end else if (decrypt_mode_we) begin
      mode_decrypt <= decrypt_mode;
    end
  end

  // Build state: used letters, fill count, last keyword letter, ready flag
  always_ff @(posedge clk) begin
    if (rst || dp_cmd.clear) begin
      letter_used <= '0;
      fill_count  <= '0;
      last_letter <= '0;
      have_last   <= 1'b0;
      table_ready <= 1'b0;
    end else begin
      if (place_en) begin
        letter_used[place_idx] <= 1'b1;
        fill_count             <= fill_count + 1'b1;
      end
      if (letter_ok) begin
        last_letter <= lower_off[IDX_W-1:0];
        have_last   <= 1'b1;
      end
      if (dp_cmd.walk_finish) begin
        table_ready <= 1'b1;
      end
    end
  end

  // Walk position and step count for the close sweep
  always_ff @(posedge clk) begin
    if (rst) begin
      walk_pos <= '0;
      walk_cnt <= '0;
    end else if (dp_cmd.walk_init) begin
      walk_cnt <= '0;
      if (!have_last || last_letter == LAST_IDX) begin
        walk_pos <= '0;
      end else begin
        walk_pos <= last_letter + 1'b1;
      end
    end else if (dp_cmd.walk_step) begin
      walk_cnt <= walk_cnt + 1'b1;
      walk_pos <= (walk_pos == LAST_IDX) ? '0 : walk_pos + 1'b1;
    end
  end

  // Write the forward and inverse tables
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < ALPHA_SIZE; i++) begin
        forward_table[i] <= IDX_W'(i);
        inverse_table[i] <= IDX_W'(i);
      end
    end else if (place_en) begin
      forward_table[fill_count[IDX_W-1:0]] <= place_idx;
      inverse_table[place_idx]             <= fill_count[IDX_W-1:0];
    end
  end

  // Register the result beat
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= dp_cmd.text;
    end
  end

  always_ff @(posedge clk) begin
    if (dp_cmd.text) begin
      out_char <= text_res;
    end
  end

endmodule

// ===== src/keyword_substitution_cipher.sv =====
// Keyword substitution cipher: a command is taken when start is high and busy
// is low. A text byte gives one result beat on out_char, marked by out_valid
// for one cycle, in the cycle after it is taken; the receiver cannot stall it.
// Start, keyword letter and text commands never raise busy. A close that
// completes the table runs a walk over the alphabet in the datapath,
// one letter per cycle, with busy high; the next command follows it. Write
// decrypt_mode only while no command is in flight.
// Top level; depends on kwsub_pkg, kwsub_ctrl and kwsub_dp.
module keyword_substitution_cipher
  import kwsub_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  output logic       busy,
  input  logic [1:0] cmd,
  input  logic [7:0] symbol,
  input  logic       decrypt_mode_we,
  input  logic       decrypt_mode,
  output logic       out_valid,
  output logic [7:0] out_char
);

  dp_cmd_t    dp_cmd;
  dp_status_t status;

  kwsub_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .cmd    (cmd),
    .status (status),
    .dp_cmd (dp_cmd),
    .busy   (busy)
  );

  kwsub_dp u_dp (
    .clk             (clk),
    .rst             (rst),
    .dp_cmd          (dp_cmd),
    .symbol          (symbol),
    .decrypt_mode_we (decrypt_mode_we),
    .decrypt_mode    (decrypt_mode),
    .status          (status),
    .out_valid       (out_valid),
    .out_char        (out_char)
  );

endmodule

// ===== bench/tb_keyword_substitution_cipher.sv =====
// Testbench for keyword_substitution_cipher: directed and random command beats,
// checked against a built-in model of the keyword table and the text mapping.
// Depends on kwsub_pkg and the keyword_substitution_cipher top level.
`timescale 1ns / 1ps

module tb_keyword_substitution_cipher;
  import kwsub_pkg::*;

  localparam int unsigned TARGET_BEATS = 1700;
  localparam int unsigned SETTLE_CYCLES = 40;

  logic       clk;
  logic       rst;
  logic       start;
  logic       busy;
  logic [1:0] cmd;
  logic [7:0] symbol;
  logic       decrypt_mode_we;
  logic       decrypt_mode;
  logic       out_valid;
  logic [7:0] out_char;

  // Model of the cipher tables and keyword build state
  logic [IDX_W-1:0] fwd_map [ALPHA_SIZE];
  logic [IDX_W-1:0] inv_map [ALPHA_SIZE];
  bit               letter_placed [ALPHA_SIZE];
  int unsigned      filled;
  logic [IDX_W-1:0] last_idx;
  bit               have_last_idx;
  bit               map_ready;
  bit               mode_decipher;

  logic [7:0]  due_chars [$];
  int unsigned beats_sent;
  int unsigned chars_checked;
  int unsigned keywords_closed;
  int unsigned mode_writes;
  int unsigned errors;

  keyword_substitution_cipher uut (
    .clk             (clk),
    .rst             (rst),
    .start           (start),
    .busy            (busy),
    .cmd             (cmd),
    .symbol          (symbol),
    .decrypt_mode_we (decrypt_mode_we),
    .decrypt_mode    (decrypt_mode),
    .out_valid       (out_valid),
    .out_char        (out_char)
  );

  always #5 clk = ~clk;

  // Drop the partial keyword; the tables keep their contents
  function automatic void restart_keyword();
    for (int i = 0; i < ALPHA_SIZE; i++) letter_placed[i] = 1'b0;
    filled        = 0;
    last_idx      = '0;
    have_last_idx = 1'b0;
    map_ready     = 1'b0;
  endfunction

  function automatic void place_in_map(input logic [IDX_W-1:0] idx);
    if (filled < ALPHA_SIZE && !letter_placed[idx]) begin
      fwd_map[filled]    = idx;
      inv_map[idx]       = IDX_W'(filled);
      letter_placed[idx] = 1'b1;
      filled++;
    end
  endfunction

  function automatic void reset_cipher_model();
    for (int i = 0; i < ALPHA_SIZE; i++) begin
      fwd_map[i] = IDX_W'(i);
      inv_map[i] = IDX_W'(i);
    end
    restart_keyword();
    mode_decipher = 1'b0;
  endfunction

  // Advance the model by one accepted beat; queue the byte a text beat returns
  function automatic void cipher_predict(input cmd_t op, input logic [7:0] sym);
    int unsigned      pos;
    logic [IDX_W-1:0] mapped;
    logic [7:0]       res;
    case (op)
      CMD_START: restart_keyword();
      CMD_LETTER: begin
        if (!map_ready && sym >= CHAR_LOWER_A && sym <= CHAR_LOWER_Z) begin
          place_in_map(IDX_W'(sym - CHAR_LOWER_A));
          last_idx      = IDX_W'(sym - CHAR_LOWER_A);
          have_last_idx = 1'b1;
        end
      end
      CMD_CLOSE: begin
        if (!map_ready) begin
          pos = have_last_idx ? (int'(last_idx) + 1) % ALPHA_SIZE : 0;
          for (int n = 0; n < ALPHA_SIZE; n++) begin
            place_in_map(IDX_W'(pos));
            pos = (pos + 1) % ALPHA_SIZE;
          end
          map_ready = 1'b1;
          keywords_closed++;
        end
      end
      default: begin
        res = sym;
        if (map_ready) begin
          if (sym >= CHAR_UPPER_A && sym <= CHAR_UPPER_Z) begin
            mapped = mode_decipher ? inv_map[sym - CHAR_UPPER_A] : fwd_map[sym - CHAR_UPPER_A];
            res    = CHAR_UPPER_A + 8'(mapped);
          end else if (sym >= CHAR_LOWER_A && sym <= CHAR_LOWER_Z) begin
            mapped = mode_decipher ? inv_map[sym - CHAR_LOWER_A] : fwd_map[sym - CHAR_LOWER_A];
            res    = CHAR_LOWER_A + 8'(mapped);
          end
        end
        due_chars.push_back(res);
      end
    endcase
  endfunction

  // Check each result beat against the oldest queued byte
  always @(posedge clk) begin
    logic [7:0] want;
    if (!rst && out_valid) begin
      if (due_chars.size() == 0) begin
        errors++;
        $display("%0t: unexpected result beat: expected none, actual %h", $time, out_char);
      end else begin
        want = due_chars.pop_front();
        chars_checked++;
        if (out_char !== want) begin
          errors++;
          $display("%0t: out_char mismatch: expected %h, actual %h", $time, want, out_char);
        end
      end
    end
  end

  // Hold one command beat on the ports until the block takes it
  task automatic send_beat(input cmd_t op, input logic [7:0] sym);
    start  <= 1'b1;
    cmd    <= op;
    symbol <= sym;
    @(posedge clk);
    while (busy) @(posedge clk);
    cipher_predict(op, sym);
    beats_sent++;
  endtask

  task automatic pause_sender(input int unsigned cycles);
    if (cycles != 0) begin
      start <= 1'b0;
      repeat (cycles) @(posedge clk);
    end
  endtask

  function automatic int unsigned pick_gap(input bit burst);
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (burst || roll < 45) return 0;
    if (roll < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Stop sending and wait until every queued byte has come back
  task automatic drain_results();
    start <= 1'b0;
    @(posedge clk);
    while (due_chars.size() != 0) @(posedge clk);
  endtask

  // Write the mode register only once the block has gone quiet
  task automatic write_mode(input bit decipher);
    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    while (busy) @(posedge clk);
    decrypt_mode_we <= 1'b1;
    decrypt_mode    <= decipher;
    @(posedge clk);
    decrypt_mode_we <= 1'b0;
    mode_decipher = decipher;
    mode_writes++;
  endtask

  function automatic logic [7:0] pick_text_byte();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 45) return 8'($urandom_range(CHAR_LOWER_A, CHAR_LOWER_Z));
    if (roll < 80) return 8'($urandom_range(CHAR_UPPER_A, CHAR_UPPER_Z));
    return 8'($urandom_range(0, 255));
  endfunction

  function automatic logic [7:0] pick_key_byte();
    if ($urandom_range(0, 99) < 82) return 8'($urandom_range(CHAR_LOWER_A, CHAR_LOWER_Z));
    return 8'($urandom_range(0, 255));
  endfunction

  // Text before any keyword is closed passes through unchanged
  task automatic test_plain_before_close();
    send_beat(CMD_TEXT, CHAR_UPPER_A);
    send_beat(CMD_TEXT, 8'h00);
    send_beat(CMD_TEXT, 8'hff);
  endtask

  // Repeated last letter, ignored bytes, and letters or close after a close
  task automatic test_keyword_build();
    send_beat(CMD_START, 8'h00);
    send_beat(CMD_LETTER, "z");
    send_beat(CMD_LETTER, "e");
    send_beat(CMD_LETTER, "b");
    send_beat(CMD_LETTER, "e");
    send_beat(CMD_LETTER, "Q");
    send_beat(CMD_LETTER, 8'h80);
    send_beat(CMD_CLOSE, 8'hff);
    send_beat(CMD_TEXT, CHAR_LOWER_A);
    send_beat(CMD_TEXT, CHAR_UPPER_Z);
    send_beat(CMD_TEXT, "~");
    send_beat(CMD_LETTER, "q");
    send_beat(CMD_CLOSE, 8'h00);
    send_beat(CMD_TEXT, CHAR_LOWER_Z);
  endtask

  // Start clears readiness, then a close with no letters walks from 'a'
  task automatic test_empty_keyword();
    send_beat(CMD_START, 8'hff);
    send_beat(CMD_TEXT, CHAR_LOWER_Z);
    send_beat(CMD_CLOSE, 8'h00);
    send_beat(CMD_TEXT, "y");
  endtask

  // Last letter 'z' wraps the fill walk to 'a'; read back through the inverse
  task automatic test_decipher();
    write_mode(1'b1);
    send_beat(CMD_START, 8'h00);
    send_beat(CMD_LETTER, CHAR_LOWER_Z);
    send_beat(CMD_CLOSE, 8'h00);
    send_beat(CMD_TEXT, CHAR_LOWER_A);
    send_beat(CMD_TEXT, CHAR_UPPER_Z);
    write_mode(1'b0);
  endtask

  // Mostly well-formed keyword sessions with random text, some broken ones
  task automatic test_random_traffic();
    int unsigned sessions;
    int unsigned key_len;
    int unsigned text_len;
    bit          burst;
    sessions = 0;
    while (beats_sent < TARGET_BEATS) begin
      burst = ($urandom_range(0, 3) == 0);
      if ($urandom_range(0, 99) < 85) begin
        send_beat(CMD_START, 8'($urandom_range(0, 255)));
        pause_sender(pick_gap(burst));
        key_len = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 45) : $urandom_range(0, 12);
        repeat (key_len) begin
          send_beat(CMD_LETTER, pick_key_byte());
          pause_sender(pick_gap(burst));
        end
        send_beat(CMD_CLOSE, 8'($urandom_range(0, 255)));
        pause_sender(pick_gap(burst));
        text_len = $urandom_range(1, 24);
        repeat (text_len) begin
          if ($urandom_range(0, 19) == 0)
            send_beat(cmd_t'($urandom_range(CMD_LETTER, CMD_CLOSE)), pick_key_byte());
          else
            send_beat(CMD_TEXT, pick_text_byte());
          pause_sender(pick_gap(burst));
        end
      end else begin
        repeat ($urandom_range(1, 8)) begin
          send_beat(cmd_t'($urandom_range(0, 3)), 8'($urandom_range(0, 255)));
          pause_sender(pick_gap(burst));
        end
      end
      sessions++;
      if (sessions % 6 == 0) write_mode(1'($urandom_range(0, 1)));
      else if (sessions % 11 == 0) drain_results();
    end
  endtask

  initial begin
    clk             = 1'b0;
    rst             = 1'b1;
    start           = 1'b0;
    cmd             = CMD_START;
    symbol          = 8'h00;
    decrypt_mode_we = 1'b0;
    decrypt_mode    = 1'b0;
    beats_sent      = 0;
    chars_checked   = 0;
    keywords_closed = 0;
    mode_writes     = 0;
    errors          = 0;
    reset_cipher_model();
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_plain_before_close();
    test_keyword_build();
    test_empty_keyword();
    test_decipher();
    test_random_traffic();

    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (due_chars.size() != 0) begin
      errors++;
      $display("%0t: %0d text results never arrived", $time, due_chars.size());
    end
    $display("Covered %0d command beats, %0d text bytes checked, %0d keyword tables built,",
             beats_sent, chars_checked, keywords_closed);
    $display("and %0d mode register writes across both cipher directions.", mode_writes);
    if (errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  // Stop a hung run
  initial begin
    #5_000_000;
    $display("Timeout at %0t", $time);
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
